[rtl/scd_pkg.sv]
package scd_pkg;

   localparam int ENTRIES = 8;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam logic [31:0] STAMP_ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_INVAL  = 2'd2;

   // one directory entry as seen on the read port
   typedef struct packed {
      logic        valid;
      logic        drive;
      logic [31:0] sector;
      logic [31:0] stamp;
   } scd_ent_type;

   // write-back request; tag_we also marks the entry valid
   typedef struct packed {
      logic             tag_we;
      logic             stamp_we;
      logic [IDX_W-1:0] idx;
      logic             drive;
      logic [31:0]      sector;
      logic [31:0]      stamp;
   } scd_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
   } scd_clr_type;

endpackage

[rtl/sector_cache_lru_directory_unit.sv]
// Tag directory of a fully associative sector cache with LRU replacement by
// access stamps. Each word on req_ is a lookup, an insert or a range
// invalidate; each gives exactly one word on rsp_. An item walks every entry
// of the tag store through its single read port, one entry per cycle, then
// writes back. One item is handled at a time: the next word is taken only in
// the idle state after write-back. req_ready is high only while no item is
// in the walk; a finished result waits in the rsp_ register and the next
// item may already be taken meanwhile. Write-back only stalls if the
// previous result has not yet been taken.
module sector_cache_lru_directory_unit import scd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic        req_drive,
   input  logic [31:0] req_sector,
   input  logic [7:0]  req_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [2:0]  rsp_slot,
   output logic [3:0]  rsp_invalidated_count
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_type;

   state_type        state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic             drive_ff, drive_in;
   logic [31:0]      sector_ff, sector_in;
   logic [31:0]      top_ff, top_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic             old_found_ff, old_found_in;
   logic [IDX_W-1:0] old_idx_ff, old_idx_in;
   logic [31:0]      old_stamp_ff, old_stamp_in;
   logic [3:0]       clr_cnt_ff, clr_cnt_in;
   logic [31:0]      counter_ff, counter_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [2:0]       rsp_slot_ff, rsp_slot_in;
   logic [3:0]       rsp_inv_ff, rsp_inv_in;

   scd_ent_type ent;
   scd_wr_type  wr;
   scd_clr_type clr;
   logic        rd_en;
   logic        issue;
   logic        tag_eq;
   logic        in_range;
   logic [31:0] counter_inc;

   scd_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (rd_en),
      .rd_idx (scan_idx_ff[IDX_W-1:0]),
      .rd_ent (ent),
      .wr     (wr),
      .clr    (clr)
   );

   assign issue       = (state_ff == ST_SCAN) && (scan_idx_ff != CNT_W'(ENTRIES));
   assign rd_en       = issue;
   assign counter_inc = counter_ff + 32'd1;
   assign tag_eq      = ent.valid && (ent.drive == drive_ff) && (ent.sector == sector_ff);
   assign in_range    = ent.valid && (ent.drive == drive_ff) &&
                        (ent.sector >= sector_ff) && (ent.sector < top_ff);

   assign req_ready             = (state_ff == ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_slot              = rsp_slot_ff;
   assign rsp_invalidated_count = rsp_inv_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      drive_in     = drive_ff;
      sector_in    = sector_ff;
      top_in       = top_ff;
      scan_idx_in  = scan_idx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = scan_idx_ff[IDX_W-1:0];
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      old_found_in = old_found_ff;
      old_idx_in   = old_idx_ff;
      old_stamp_in = old_stamp_ff;
      clr_cnt_in   = clr_cnt_ff;
      counter_in   = counter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_inv_in   = rsp_inv_ff;
      wr           = '0;
      clr          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_cmd;
               drive_in     = req_drive;
               sector_in    = req_sector;
               top_in       = req_sector + 32'(req_count);
               scan_idx_in  = '0;
               found_in     = 1'b0;
               old_found_in = 1'b0;
               old_stamp_in = STAMP_ALL_ONES;
               clr_cnt_in   = '0;
               state_in     = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
               chk_vld_in  = 1'b1;
            end else begin
               state_in = ST_COMMIT;
            end
            // read data of the previous cycle's address
            if (chk_vld_ff) begin
               case (cmd_ff)
                  CMD_LOOKUP: begin
                     if (!found_ff && tag_eq) begin
                        found_in     = 1'b1;
                        found_idx_in = chk_idx_ff;
                     end
                  end
                  CMD_INSERT: begin
                     if (!found_ff && !ent.valid) begin
                        found_in     = 1'b1;
                        found_idx_in = chk_idx_ff;
                     end
                     if (ent.valid && (ent.stamp < old_stamp_ff)) begin
                        old_found_in = 1'b1;
                        old_idx_in   = chk_idx_ff;
                        old_stamp_in = ent.stamp;
                     end
                  end
                  CMD_INVAL: begin
                     if (in_range) begin
                        clr.en  = 1'b1;
                        clr.idx = chk_idx_ff;
                        if (clr_cnt_ff != 4'hF) begin
                           clr_cnt_in = clr_cnt_ff + 4'd1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_slot_in  = '0;
               rsp_inv_in   = '0;
               state_in     = ST_IDLE;
               case (cmd_ff)
                  CMD_LOOKUP: begin
                     if (found_ff) begin
                        wr.stamp_we = 1'b1;
                        wr.idx      = found_idx_ff;
                        wr.stamp    = counter_inc;
                        counter_in  = counter_inc;
                        rsp_hit_in  = 1'b1;
                        rsp_slot_in = 3'(found_idx_ff);
                     end
                  end
                  CMD_INSERT: begin
                     // first free entry, else oldest stamp below all-ones
                     if (found_ff || old_found_ff) begin
                        wr.tag_we   = 1'b1;
                        wr.stamp_we = 1'b1;
                        wr.idx      = found_ff ? found_idx_ff : old_idx_ff;
                        wr.drive    = drive_ff;
                        wr.sector   = sector_ff;
                        wr.stamp    = counter_inc;
                        counter_in  = counter_inc;
                        rsp_hit_in  = 1'b1;
                        rsp_slot_in = 3'(found_ff ? found_idx_ff : old_idx_ff);
                     end
                  end
                  CMD_INVAL: begin
                     rsp_inv_in = clr_cnt_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      drive_ff     <= drive_in;
      sector_ff    <= sector_in;
      top_ff       <= top_in;
      scan_idx_ff  <= scan_idx_in;
      chk_idx_ff   <= chk_idx_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      old_found_ff <= old_found_in;
      old_idx_ff   <= old_idx_in;
      old_stamp_ff <= old_stamp_in;
      clr_cnt_ff   <= clr_cnt_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_inv_ff   <= rsp_inv_in;
   end

   // a result still waiting holds the write-back back
   a_commit_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) && rsp_valid_ff && !rsp_ready |=> (state_ff == ST_COMMIT))
      else $error("write-back overran a waiting result");

   // the stamp counter moves only on write-back
   a_counter_commit: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(counter_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("stamp counter moved outside write-back");

   // check stage trails the read address by exactly one entry
   a_chk_trails: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (CNT_W'(chk_idx_ff) + CNT_W'(1) == scan_idx_ff))
      else $error("check stage out of step with read address");

   // no read-back during write-back, so no forwarding is needed
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr.tag_we || wr.stamp_we) |-> !rd_en && !chk_vld_ff)
      else $error("store written while a walk is in flight");

endmodule

[rtl/scd_store.sv]
module scd_store import scd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output scd_ent_type      rd_ent,
   input  scd_wr_type       wr,
   input  scd_clr_type      clr
);

   logic [32:0]        tag_mem   [ENTRIES];
   logic [31:0]        stamp_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic [32:0] rd_tag_ff;
   logic [31:0] rd_stamp_ff;
   logic        rd_valid_ff;

   // tag and stamp stores: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr.tag_we) begin
         tag_mem[wr.idx] <= {wr.drive, wr.sector};
      end
      if (wr.stamp_we) begin
         stamp_mem[wr.idx] <= wr.stamp;
      end
      if (rd_en) begin
         rd_tag_ff   <= tag_mem[rd_idx];
         rd_stamp_ff <= stamp_mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   // valid bits gate every use of the stores, so those need no clearing
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (clr.en) begin
            valid_ff[clr.idx] <= 1'b0;
         end
         if (wr.tag_we) begin
            valid_ff[wr.idx] <= 1'b1;
         end
      end
   end

   assign rd_ent.valid  = rd_valid_ff;
   assign rd_ent.drive  = rd_tag_ff[32];
   assign rd_ent.sector = rd_tag_ff[31:0];
   assign rd_ent.stamp  = rd_stamp_ff;

endmodule

[sim/tb_sector_cache_lru_directory_unit.sv]
`timescale 1ns / 1ps

module tb_sector_cache_lru_directory_unit;
   import scd_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       hit;
      logic [2:0] slot;
      logic [3:0] cleared;
   } dir_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic        req_drive;
   logic [31:0] req_sector;
   logic [7:0]  req_count;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit;
   logic [2:0]  rsp_slot;
   logic [3:0]  rsp_invalidated_count;

   // shadow directory
   logic        dir_valid [ENTRIES];
   logic        dir_drive [ENTRIES];
   logic [31:0] dir_sector [ENTRIES];
   logic [31:0] dir_stamp [ENTRIES];
   logic [31:0] stamp_counter;

   dir_result_type pending_results [$];

   bit idle_enable = 1'b1;
   int stall_left = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int words_sent = 0;
   int lookup_hits = 0;
   int replacements = 0;
   int entries_cleared = 0;
   int dropped_inserts = 0;

   sector_cache_lru_directory_unit uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_drive             (req_drive),
      .req_sector            (req_sector),
      .req_count             (req_count),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_hit               (rsp_hit),
      .rsp_slot              (rsp_slot),
      .rsp_invalidated_count (rsp_invalidated_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timed out with %0d results pending", $time, pending_results.size());
      $display("sector_cache_lru_directory_unit verification failed");
      $finish;
   end

   // receiver: stalls in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void reset_directory();
      int i;
      for (i = 0; i < ENTRIES; i++) begin
         dir_valid[i] = 1'b0;
         dir_drive[i] = 1'b0;
         dir_sector[i] = '0;
         dir_stamp[i] = '0;
      end
      stamp_counter = '0;
   endfunction

   function automatic dir_result_type predict_directory(input logic [1:0] cmd,
         input logic drive, input logic [31:0] sector, input logic [7:0] count);
      dir_result_type res;
      int i;
      int pick;
      int oldest;
      logic [31:0] least_stamp;
      logic [31:0] top;
      bit done;
      res = '0;
      pick = -1;
      oldest = -1;
      least_stamp = STAMP_ALL_ONES;
      done = 1'b0;
      top = sector + {24'd0, count};
      case (cmd)
         CMD_LOOKUP: begin
            // first matching slot wins
            for (i = 0; i < ENTRIES; i++) begin
               if (!done && dir_valid[i] && dir_drive[i] == drive &&
                     dir_sector[i] == sector) begin
                  done = 1'b1;
                  stamp_counter = stamp_counter + 32'd1;
                  dir_stamp[i] = stamp_counter;
                  res.hit = 1'b1;
                  res.slot = 3'(i);
                  lookup_hits++;
               end
            end
         end
         CMD_INSERT: begin
            for (i = 0; i < ENTRIES; i++) begin
               if (!done) begin
                  if (!dir_valid[i]) begin
                     pick = i;
                     done = 1'b1;
                  end else if (dir_stamp[i] < least_stamp) begin
                     oldest = i;
                     least_stamp = dir_stamp[i];
                  end
               end
            end
            if (pick < 0) begin
               pick = oldest;
               if (oldest >= 0) replacements++;
               else dropped_inserts++;
            end
            if (pick >= 0) begin
               dir_valid[pick] = 1'b1;
               dir_drive[pick] = drive;
               dir_sector[pick] = sector;
               stamp_counter = stamp_counter + 32'd1;
               dir_stamp[pick] = stamp_counter;
               res.hit = 1'b1;
               res.slot = 3'(pick);
            end
         end
         CMD_INVAL: begin
            // a range that wraps past the top gives top <= sector: no match
            for (i = 0; i < ENTRIES; i++) begin
               if (dir_valid[i] && dir_drive[i] == drive && dir_sector[i] >= sector &&
                     dir_sector[i] < top) begin
                  dir_valid[i] = 1'b0;
                  if (res.cleared != 4'd15) res.cleared = res.cleared + 4'd1;
                  entries_cleared++;
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : check_results
      dir_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none, %s %0d slot %0d cleared %0d",
               $time, "actual hit", rsp_hit, rsp_slot, rsp_invalidated_count);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit mismatch, expected %0d, actual %0d", $time, want.hit, rsp_hit);
               fail_count++;
            end
            if (rsp_slot !== want.slot) begin
               $display("%0t: slot mismatch, expected %0d, actual %0d",
                  $time, want.slot, rsp_slot);
               fail_count++;
            end
            if (rsp_invalidated_count !== want.cleared) begin
               $display("%0t: invalidated_count mismatch, expected %0d, actual %0d",
                  $time, want.cleared, rsp_invalidated_count);
               fail_count++;
            end
         end
      end
   end

   task automatic send_word(input logic [1:0] cmd, input logic drive,
         input logic [31:0] sector, input logic [7:0] count);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_drive <= drive;
      req_sector <= sector;
      req_count <= count;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_results.push_back(predict_directory(cmd, drive, sector, count));
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_lookup_insert();
      send_word(CMD_LOOKUP, 1'b0, 32'd0, 8'd0);            // miss on empty directory
      send_word(CMD_INSERT, 1'b0, 32'd0, 8'd0);
      send_word(CMD_INSERT, 1'b1, 32'hFFFF_FFFF, 8'hFF);
      send_word(CMD_LOOKUP, 1'b1, 32'hFFFF_FFFF, 8'hFF);
      send_word(CMD_LOOKUP, 1'b0, 32'hFFFF_FFFF, 8'd0);    // same sector, other drive
      send_word(CMD_INSERT, 1'b0, 32'd0, 8'd1);            // second copy of sector 0
      send_word(CMD_LOOKUP, 1'b0, 32'd0, 8'd0);            // lowest copy answers
   endtask

   task automatic test_lru_replacement();
      int i;
      for (i = 0; i < ENTRIES - 3; i++)
         send_word(CMD_INSERT, 1'b0, 32'd100 + i, 8'd0);
      send_word(CMD_LOOKUP, 1'b1, 32'hFFFF_FFFF, 8'd0);    // refresh so slot 2 is oldest
      send_word(CMD_INSERT, 1'b1, 32'h8000_0000, 8'd0);
      send_word(CMD_INSERT, 1'b0, 32'h5A5A_A5A5, 8'd0);
   endtask

   task automatic test_range_invalidate();
      send_word(CMD_INVAL, 1'b0, 32'd100, 8'd3);
      send_word(CMD_INVAL, 1'b0, 32'd0, 8'd0);             // empty range
      send_word(CMD_INVAL, 1'b1, 32'hFFFF_FFF0, 8'hFF);    // end wraps past the top
      send_word(CMD_INVAL, 1'b0, 32'd0, 8'hFF);
      send_word(CMD_INSERT, 1'b0, 32'd7, 8'd0);            // refills a freed slot
   endtask

   task automatic test_unused_cmd();
      send_word(CMD_NONE, 1'b1, 32'hFFFF_FFFF, 8'hFF);
      send_word(CMD_NONE, 1'b0, 32'd0, 8'd0);
   endtask

   task automatic random_word(input logic [31:0] base);
      int pick;
      logic [1:0] cmd;
      logic [31:0] sector;
      logic [7:0] count;
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_LOOKUP;
      else if (pick < 80) cmd = CMD_INSERT;
      else if (pick < 95) cmd = CMD_INVAL;
      else cmd = CMD_NONE;
      // mostly a small working set so lookups hit and ranges clear something
      if ($urandom_range(0, 9) == 0) sector = $urandom;
      else sector = base + $urandom_range(0, 15);
      pick = $urandom_range(0, 9);
      if (pick == 0) count = 8'd0;
      else if (pick < 3) count = 8'($urandom_range(0, 255));
      else count = 8'($urandom_range(1, 24));
      send_word(cmd, 1'($urandom_range(0, 1)), sector, count);
   endtask

   function automatic logic [31:0] pick_base();
      case ($urandom_range(0, 3))
         0: return 32'hFFFF_FFF0;
         1: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random_traffic(input int words);
      int i;
      logic [31:0] base;
      base = 32'd0;
      for (i = 0; i < words; i++) begin
         if (i % 64 == 0) base = pick_base();
         if (i == words / 2) wait_drained();
         random_word(base);
      end
   endtask

   task automatic test_steady_stream(input int words);
      int i;
      logic [31:0] base;
      idle_enable = 1'b0;
      base = pick_base();
      for (i = 0; i < words; i++) begin
         if (i % 50 == 0) base = pick_base();
         random_word(base);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_LOOKUP;
      req_drive <= 1'b0;
      req_sector <= '0;
      req_count <= '0;
      reset_directory();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_lookup_insert();
      test_lru_replacement();
      test_range_invalidate();
      test_unused_cmd();
      test_random_traffic(1050);
      test_steady_stream(150);

      wait_drained();
      repeat (4 * ENTRIES) @(posedge clock);
      $display("%0d words: %0d lookup hits, %0d LRU replacements, %0d entries invalidated",
         words_sent, lookup_hits, replacements, entries_cleared);
      $display("no-victim drops %0d, %0d mismatches", dropped_inserts, fail_count);
      if (fail_count == 0)
         $display("sector_cache_lru_directory_unit verification clean");
      else
         $display("sector_cache_lru_directory_unit verification failed");
      $finish;
   end

endmodule

[sector_cache_lru_directory_unit.f]
rtl/scd_pkg.sv
rtl/scd_store.sv
rtl/sector_cache_lru_directory_unit.sv
sim/tb_sector_cache_lru_directory_unit.sv
